### src/mcfp_pkg.sv
// Shared types and constants of the MAC command frame parser
package mcfp_pkg;

   // header capture
   localparam int HdrKeep = 24;
   localparam int PosW    = 9;
   localparam int LenW    = PosW + 1;
   localparam int OffW    = 5;
   localparam int WinBytes = 11;

   localparam logic [PosW-1:0] POS_MAX      = 9'd511;
   localparam logic [PosW-1:0] POS_OVERLONG = 9'd255;

   // frame control codes
   localparam logic [2:0] FRAME_TYPE_COMMAND = 3'd3;
   localparam logic [1:0] ADDR_MODE_NONE     = 2'd0;
   localparam logic [1:0] ADDR_MODE_RESERVED = 2'd1;
   localparam logic [1:0] ADDR_MODE_SHORT    = 2'd2;
   localparam logic [1:0] ADDR_MODE_EXT      = 2'd3;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_TOO_SHORT     = 3'd1,
      STATUS_NOT_COMMAND   = 3'd2,
      STATUS_RESERVED_MODE = 3'd3,
      STATUS_OVERLONG      = 3'd4
   } status_type;

   typedef logic [HdrKeep-1:0][7:0]  hdr_bytes_type;
   typedef logic [WinBytes-1:0][7:0] win_bytes_type;

   // header view handed from capture to decode
   typedef struct packed {
      logic            done;
      logic [PosW-1:0] pos;
      hdr_bytes_type   hdr;
   } frame_view_type;

   // one decoded result word
   typedef struct packed {
      status_type  status;
      logic [7:0]  sequence_number;
      logic [1:0]  dest_addr_mode;
      logic [1:0]  source_addr_mode;
      logic [15:0] dest_pan_id;
      logic [63:0] dest_address;
      logic [15:0] source_pan_id;
      logic [63:0] source_address;
      logic [7:0]  command_id;
      logic        ack_request;
      logic        pan_compressed;
      logic [7:0]  payload_length;
   } rsp_fields_type;

endpackage

### src/mcfp_capture.sv
// Byte counter and header byte store of the frame parser
module mcfp_capture (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              frame_byte,
   input  logic                    last_byte,
   output mcfp_pkg::frame_view_type view
);
   import mcfp_pkg::*;

   logic [PosW-1:0] pos_ff, pos_in;
   hdr_bytes_type   hdr_ff;
   logic            keep;

   assign keep = (pos_ff < PosW'(HdrKeep));

   // byte position, saturating, back to zero after the last word
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (last_byte) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // header store, one byte written per accepted word among the first HdrKeep bytes
   always_ff @(posedge clock) begin
      if (accept && keep) begin
         hdr_ff[pos_ff[OffW-1:0]] <= frame_byte;
      end
   end

   // header as it stands after this word, for end-of-frame decode
   always_comb begin
      for (int k = 0; k < HdrKeep; k++) begin
         view.hdr[k] = (pos_ff == PosW'(k)) ? frame_byte : hdr_ff[k];
      end
      view.pos  = pos_ff;
      view.done = accept && last_byte;
   end

endmodule

### src/mcfp_decode.sv
// End-of-frame decode of the MAC header fields and status
module mcfp_decode (
   input  mcfp_pkg::frame_view_type view,
   output mcfp_pkg::rsp_fields_type fields
);
   import mcfp_pkg::*;

   logic [LenW-1:0] len;
   logic [15:0]     fcf;
   logic [2:0]      ftype;
   logic [1:0]      dmode, smode;
   logic            comp, ack;
   logic [15:0]     d_pan, s_pan;
   logic [63:0]     d_addr, s_addr;
   logic [OffW-1:0] s_start, s_used, s_end, cmd_end;
   win_bytes_type   win;
   logic [7:0]      cmd;
   status_type      status;

   assign len   = {1'b0, view.pos} + LenW'(1);
   assign fcf   = {view.hdr[1], view.hdr[0]};
   assign ftype = fcf[2:0];
   assign dmode = fcf[11:10];
   assign smode = fcf[15:14];
   assign comp  = fcf[6];
   assign ack   = fcf[5];

   // destination fields and where the source fields start
   always_comb begin
      case (dmode)
         ADDR_MODE_SHORT: begin
            d_pan   = view.hdr[4:3];
            d_addr  = {48'd0, view.hdr[6:5]};
            s_start = OffW'(7);
            win     = view.hdr[17:7];
         end
         ADDR_MODE_EXT: begin
            d_pan   = view.hdr[4:3];
            d_addr  = view.hdr[12:5];
            s_start = OffW'(13);
            win     = view.hdr[23:13];
         end
         default: begin
            d_pan   = '0;
            d_addr  = '0;
            s_start = OffW'(3);
            win     = view.hdr[13:3];
         end
      endcase
   end

   // source fields and command byte, taken from the window after the destination
   always_comb begin
      s_pan  = '0;
      s_addr = '0;
      s_used = '0;
      cmd    = win[0];
      case (smode)
         ADDR_MODE_SHORT: begin
            if (comp) begin
               s_pan  = d_pan;
               s_addr = {48'd0, win[1:0]};
               s_used = OffW'(2);
               cmd    = win[2];
            end else begin
               s_pan  = win[1:0];
               s_addr = {48'd0, win[3:2]};
               s_used = OffW'(4);
               cmd    = win[4];
            end
         end
         ADDR_MODE_EXT: begin
            if (comp) begin
               s_pan  = d_pan;
               s_addr = win[7:0];
               s_used = OffW'(8);
               cmd    = win[8];
            end else begin
               s_pan  = win[1:0];
               s_addr = win[9:2];
               s_used = OffW'(10);
               cmd    = win[10];
            end
         end
         default: begin
            s_pan  = '0;
            s_addr = '0;
            s_used = '0;
            cmd    = win[0];
         end
      endcase
   end

   assign s_end   = s_start + s_used;
   assign cmd_end = s_end + OffW'(1);

   // checks in priority order
   always_comb begin
      if (view.pos >= POS_OVERLONG) begin
         status = STATUS_OVERLONG;
      end else if (len < LenW'(4)) begin
         status = STATUS_TOO_SHORT;
      end else if (ftype != FRAME_TYPE_COMMAND) begin
         status = STATUS_NOT_COMMAND;
      end else if ((dmode != ADDR_MODE_NONE) && (len < LenW'(5))) begin
         status = STATUS_TOO_SHORT;
      end else if (dmode == ADDR_MODE_RESERVED) begin
         status = STATUS_RESERVED_MODE;
      end else if ((dmode != ADDR_MODE_NONE) && (len < LenW'(s_start))) begin
         status = STATUS_TOO_SHORT;
      end else if ((smode != ADDR_MODE_NONE) && !comp &&
                   (len < LenW'(s_start) + LenW'(2))) begin
         status = STATUS_TOO_SHORT;
      end else if (smode == ADDR_MODE_RESERVED) begin
         status = STATUS_RESERVED_MODE;
      end else if ((smode != ADDR_MODE_NONE) && (len < LenW'(s_end))) begin
         status = STATUS_TOO_SHORT;
      end else if (len < LenW'(cmd_end)) begin
         status = STATUS_TOO_SHORT;
      end else begin
         status = STATUS_OK;
      end
   end

   // result word, all zero but status on error
   always_comb begin
      fields        = '0;
      fields.status = status;
      if (status == STATUS_OK) begin
         fields.sequence_number  = view.hdr[2];
         fields.dest_addr_mode   = dmode;
         fields.source_addr_mode = smode;
         fields.dest_pan_id      = d_pan;
         fields.dest_address     = d_addr;
         fields.source_pan_id    = s_pan;
         fields.source_address   = s_addr;
         fields.command_id       = cmd;
         fields.ack_request      = ack;
         fields.pan_compressed   = comp;
         fields.payload_length   = 8'(len - LenW'(cmd_end));
      end
   end

endmodule

### src/mcfp_rsp_buffer.sv
// Result register with skid stage on the response side
module mcfp_rsp_buffer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    new_valid,
   input  mcfp_pkg::rsp_fields_type new_fields,
   output logic                    space,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mcfp_pkg::rsp_fields_type rsp_fields
);
   import mcfp_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   rsp_fields_type out_ff, out_in;
   rsp_fields_type skid_ff, skid_in;
   logic           out_free;

   assign out_free = !out_valid_ff || rsp_ready;
   assign space    = !skid_valid_ff;

   // refill the output word from the skid stage first, else from decode
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_valid;
            out_in       = new_fields;
         end
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = new_fields;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_fields = out_ff;

endmodule

### src/mac_command_frame_parser.sv
// Top level of the MAC command frame parser
// Takes one received 802.15.4 frame a byte per word on req_, tlast on the
// final byte, and gives one decoded command header word on rsp_ per frame.
// A byte is taken every cycle while req_tready is high; the result of a
// frame is set by one pass of decode logic between the header byte store
// and the result register, or the skid stage while the result register
// holds a word. The skid stage keeps req_tready high while one result
// waits on rsp_tready; it drops only while both stages hold words.
// Status in rsp_tuser: 0 ok, 1 too short, 2 not a command, 3 reserved
// address mode, 4 longer than 255 bytes; on error all of rsp_tdata is zero.
module mac_command_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] frame_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] sequence_number, [9:8] dest_addr_mode, [11:10] source_addr_mode,
   // [27:12] dest_pan_id, [91:28] dest_address, [107:92] source_pan_id,
   // [171:108] source_address, [179:172] command_id, [180] ack_request,
   // [181] pan_compressed, [189:182] payload_length, [191:190] zero
   output logic [191:0] rsp_tdata,
   output logic [2:0]   rsp_tuser    // [2:0] status
);
   import mcfp_pkg::*;

   logic           accept;
   logic           space;
   frame_view_type view;
   rsp_fields_type dec_fields;
   rsp_fields_type out_fields;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   mcfp_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_tdata),
      .last_byte  (req_tlast),
      .view       (view)
   );

   mcfp_decode u_decode (
      .view   (view),
      .fields (dec_fields)
   );

   mcfp_rsp_buffer u_rsp_buffer (
      .clock      (clock),
      .reset      (reset),
      .new_valid  (view.done),
      .new_fields (dec_fields),
      .space      (space),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_fields (out_fields)
   );

   // pack the result word
   assign rsp_tuser = out_fields.status;
   assign rsp_tdata = {2'b00,
                       out_fields.payload_length,
                       out_fields.pan_compressed,
                       out_fields.ack_request,
                       out_fields.command_id,
                       out_fields.source_address,
                       out_fields.source_pan_id,
                       out_fields.dest_address,
                       out_fields.dest_pan_id,
                       out_fields.source_addr_mode,
                       out_fields.dest_addr_mode,
                       out_fields.sequence_number};

endmodule
